@@ hw/rtl/pbs_pkg.sv @@
// Shared types, constants and helpers for the polyline Bezier smoother.
package pbs_pkg;

    localparam int CW = 32;               // coordinate width
    localparam int DW = CW + 2;           // coordinate difference width
    localparam int MW = CW + 1;           // difference magnitude width
    localparam int LW = CW + 1;           // length width
    localparam int QW = 17;               // Q16 ratio / weight width
    localparam int SQ_STEPS = LW;         // sqrt result bits
    localparam int DV_STEPS = 16;         // ratio quotient bits

    localparam logic [1:0] KIND_MOVE  = 2'd0;
    localparam logic [1:0] KIND_LINE  = 2'd1;
    localparam logic [1:0] KIND_CURVE = 2'd2;

    localparam logic [QW-1:0] ONE_Q16 = 17'd65536;

    // One curve job: the four points a, b, c, d.
    // Phantom neighbours (2b-c, 2c-b) need two bits of headroom.
    typedef struct packed {
        logic signed [DW-1:0] ax;
        logic signed [DW-1:0] ay;
        logic signed [CW-1:0] bx;
        logic signed [CW-1:0] by;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
    } t_quad;

    // Per-item control carried alongside the curve data.
    typedef struct packed {
        logic [1:0] kind;
        logic       done;
    } t_ctl;

    function automatic logic signed [CW-1:0] sat_c(input logic signed [DW+1:0] v);
        logic signed [DW+1:0] hi;
        logic signed [DW+1:0] lo;
        hi = (DW+2)'((longint'(1) << (CW-1)) - 1);
        lo = -(DW+2)'(longint'(1) << (CW-1));
        if (v > hi) return hi[CW-1:0];
        if (v < lo) return lo[CW-1:0];
        return v[CW-1:0];
    endfunction

endpackage

@@ hw/rtl/pbs_curve_pipe.sv @@
// Pipelined cubic control point unit: lengths, ratios, weights, corrections.
module pbs_curve_pipe
    import pbs_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  logic            i_valid,
    input  t_quad           i_quad,
    input  t_ctl            i_ctl,
    input  logic [QW-1:0]   i_smooth,
    output logic            o_valid,
    output t_ctl            o_ctl,
    output logic signed [CW-1:0] o_c1x,
    output logic signed [CW-1:0] o_c1y,
    output logic signed [CW-1:0] o_c2x,
    output logic signed [CW-1:0] o_c2y,
    output logic signed [CW-1:0] o_ex,
    output logic signed [CW-1:0] o_ey
);

    // Stage totals: 2 (square) + SQ_STEPS (sqrt) + DV_STEPS (div)
    // + 1 (weight) + 2 (scale) + 1 (sum/sat).
    localparam int SW = 2*LW;              // squared-sum width (bits)
    localparam int NST = 2 + SQ_STEPS + DV_STEPS + 3;   // index of the last stage

    typedef struct packed {
        t_quad quad;
        t_ctl  ctl;
        logic [QW-1:0] s;
    } t_carry;

    // ---------- stage 0: differences and magnitudes ----------
    logic signed [DW-1:0] d1x, d1y, d2x, d2y, d3x, d3y;
    always_comb begin
        d1x = DW'(i_quad.bx) - DW'(i_quad.ax);
        d1y = DW'(i_quad.by) - DW'(i_quad.ay);
        d2x = DW'(i_quad.cx) - DW'(i_quad.bx);
        d2y = DW'(i_quad.cy) - DW'(i_quad.by);
        d3x = DW'(i_quad.dx) - DW'(i_quad.cx);
        d3y = DW'(i_quad.dy) - DW'(i_quad.cy);
    end

    function automatic logic [MW:0] mag(input logic signed [DW-1:0] v);
        return v[DW-1] ? (MW+1)'(-v) : (MW+1)'(v);
    endfunction

    logic [MW:0] r_m [6];
    logic [NST:0] r_v;
    t_carry r_c [NST+1];

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_m[0] <= mag(d1x); r_m[1] <= mag(d1y);
            r_m[2] <= mag(d2x); r_m[3] <= mag(d2y);
            r_m[4] <= mag(d3x); r_m[5] <= mag(d3y);
            r_c[0] <= '{quad: i_quad, ctl: i_ctl,
                        s: (i_smooth > ONE_Q16) ? ONE_Q16 : i_smooth};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_adv) begin
            r_v <= {r_v[NST-1:0], i_valid};
        end
    end

    // ---------- stage 1: squares summed ----------
    logic [SW-1:0] r_sq [3];
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int k = 0; k < 3; k++)
                r_sq[k] <= SW'(r_m[2*k]) * SW'(r_m[2*k]) +
                           SW'(r_m[2*k+1]) * SW'(r_m[2*k+1]);
            r_c[1] <= r_c[0];
        end
    end

    // ---------- sqrt: one result bit per stage ----------
    logic [SW-1:0] r_sqv [SQ_STEPS+1][3];
    logic [LW+1:0] r_rem [SQ_STEPS+1][3];
    logic [LW-1:0] r_root[SQ_STEPS+1][3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            r_sqv[0][k]  = r_sq[k];
            r_rem[0][k]  = '0;
            r_root[0][k] = '0;
        end
    end

    for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqrt
        for (genvar k = 0; k < 3; k++) begin : g_lane
            logic [LW+1:0] rem_n, t_n;
            always_comb begin
                rem_n = {r_rem[g][k][LW-1:0], r_sqv[g][k][SW-1 -: 2]};
                t_n   = {r_root[g][k], 2'b01};
            end
            always_ff @(posedge i_clk) begin
                if (i_adv) begin
                    r_sqv[g+1][k] <= r_sqv[g][k] << 2;
                    if (rem_n >= t_n) begin
                        r_rem[g+1][k]  <= rem_n - t_n;
                        r_root[g+1][k] <= {r_root[g][k][LW-2:0], 1'b1};
                    end else begin
                        r_rem[g+1][k]  <= rem_n;
                        r_root[g+1][k] <= {r_root[g][k][LW-2:0], 1'b0};
                    end
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_adv) r_c[2+g] <= r_c[1+g];
        end
    end

    // ---------- ratio: restoring division, one bit per stage ----------
    localparam int DB = 2 + SQ_STEPS;
    logic [LW:0]  r_sum [DV_STEPS+1][2];
    logic [LW:0]  r_rr  [DV_STEPS+1][2];
    logic [QW-1:0] r_q  [DV_STEPS+1][2];
    logic         r_sp  [DV_STEPS+1][2];   // special: zero sum or full

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            r_sum[0][k] = (LW+1)'(r_root[SQ_STEPS][k]) + (LW+1)'(r_root[SQ_STEPS][k+1]);
            r_rr[0][k]  = (LW+1)'(r_root[SQ_STEPS][k]);
            r_sp[0][k]  = (r_sum[0][k] == '0) || (r_rr[0][k] >= r_sum[0][k]);
            r_q[0][k]   = (r_sum[0][k] == '0) ? '0 :
                          (r_rr[0][k] >= r_sum[0][k]) ? ONE_Q16 : '0;
        end
    end

    for (genvar g = 0; g < DV_STEPS; g++) begin : g_div
        for (genvar k = 0; k < 2; k++) begin : g_lane
            logic [LW+1:0] sh;
            always_comb sh = {r_rr[g][k], 1'b0};
            always_ff @(posedge i_clk) begin
                if (i_adv) begin
                    r_sum[g+1][k] <= r_sum[g][k];
                    r_sp[g+1][k]  <= r_sp[g][k];
                    if (r_sp[g][k]) begin
                        r_rr[g+1][k] <= r_rr[g][k];
                        r_q[g+1][k]  <= r_q[g][k];
                    end else if (sh >= (LW+2)'(r_sum[g][k])) begin
                        r_rr[g+1][k] <= (LW+1)'(sh - (LW+2)'(r_sum[g][k]));
                        r_q[g+1][k]  <= {r_q[g][k][QW-2:0], 1'b1};
                    end else begin
                        r_rr[g+1][k] <= sh[LW:0];
                        r_q[g+1][k]  <= {r_q[g][k][QW-2:0], 1'b0};
                    end
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_adv) r_c[DB+g] <= r_c[DB-1+g];
        end
    end

    // ---------- weights ----------
    localparam int WB = DB + DV_STEPS;
    t_carry cw;
    assign cw = r_c[WB-1];
    logic [QW-1:0] r_w1, r_w2;
    logic [2*QW-1:0] p1, p2;
    always_comb begin
        p1 = (2*QW)'(cw.s) * (2*QW)'(ONE_Q16 - r_q[DV_STEPS][0]) + (2*QW)'(32768);
        p2 = (2*QW)'(cw.s) * (2*QW)'(r_q[DV_STEPS][1]) + (2*QW)'(32768);
    end
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_w1 <= p1[QW+15:16];
            r_w2 <= p2[QW+15:16];
            r_c[WB] <= cw;
        end
    end

    // ---------- scale: products of magnitude halves ----------
    t_carry cs;
    assign cs = r_c[WB];
    logic signed [DW-1:0] e [4];
    always_comb begin
        e[0] = DW'(cs.quad.cx) - DW'(cs.quad.ax);
        e[1] = DW'(cs.quad.cy) - DW'(cs.quad.ay);
        e[2] = DW'(cs.quad.dx) - DW'(cs.quad.bx);
        e[3] = DW'(cs.quad.dy) - DW'(cs.quad.by);
    end
    localparam int HW = DW - 16;
    logic [HW+QW-1:0] r_ph [4];
    logic [16+QW:0]   r_pl [4];
    logic             r_neg[4];
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int k = 0; k < 4; k++) begin
                r_neg[k] <= e[k][DW-1];
                r_ph[k]  <= (HW+QW)'(mag(e[k]) >> 16) * (HW+QW)'((k < 2) ? r_w1 : r_w2);
                r_pl[k]  <= (17+QW)'(mag(e[k]) & (MW+1)'(16'hffff))
                          * (17+QW)'((k < 2) ? r_w1 : r_w2) + (17+QW)'(65536);
            end
            r_c[WB+1] <= cs;
        end
    end

    logic [DW:0] r_res [4];
    logic        r_rn  [4];
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int k = 0; k < 4; k++) begin
                r_rn[k]  <= r_neg[k];
                r_res[k] <= (DW+1)'(r_ph[k] >> 1) +
                            (DW+1)'(((HW+QW+1)'(r_ph[k][0]) << 16) + (HW+QW+1)'(r_pl[k]) >> 17);
            end
            r_c[WB+2] <= r_c[WB+1];
        end
    end

    // ---------- final sum and saturation ----------
    t_carry cf;
    assign cf = r_c[WB+2];
    logic signed [DW+1:0] cor [4];
    always_comb begin
        for (int k = 0; k < 4; k++)
            cor[k] = r_rn[k] ? -(DW+2)'(r_res[k]) : (DW+2)'(r_res[k]);
    end
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            o_c1x <= sat_c((DW+2)'(cf.quad.bx) + cor[0]);
            o_c1y <= sat_c((DW+2)'(cf.quad.by) + cor[1]);
            o_c2x <= sat_c((DW+2)'(cf.quad.cx) - cor[2]);
            o_c2y <= sat_c((DW+2)'(cf.quad.cy) - cor[3]);
            o_ex  <= cf.quad.cx;
            o_ey  <= cf.quad.cy;
            o_ctl <= cf.ctl;
            r_c[WB+3] <= cf;
        end
    end

    assign o_valid = r_v[NST];

    logic unused;
    assign unused = ^r_c[NST];

endmodule

@@ hw/rtl/polyline_bezier_smoother.sv @@
// From point accept to result the curve pipeline has 2 square, 33 sqrt, 16 divide,
// 1 weight, 2 scale and 1 saturate stage, the last into the output register.
// Throughput: one point per cycle while o_stall is low; a final point of three or more
// holds o_stall high while it issues its second curve down the same pipeline.
// Moves and lines ride the same pipeline with control points forced to zero.
// Synchronous active-low reset clears the window count and valid bits and sets smoothing to one.
module polyline_bezier_smoother
    import pbs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  logic signed [CW-1:0] i_point_x,
    input  logic signed [CW-1:0] i_point_y,
    input  logic i_last_point,
    input  logic i_cfg_valid,
    output logic o_cfg_ready,
    input  logic [QW-1:0] i_cfg_smoothing,
    output logic o_valid,
    input  logic i_stall,
    output logic [1:0] o_segment_kind,
    output logic signed [CW-1:0] o_ctrl1_x,
    output logic signed [CW-1:0] o_ctrl1_y,
    output logic signed [CW-1:0] o_ctrl2_x,
    output logic signed [CW-1:0] o_ctrl2_y,
    output logic signed [CW-1:0] o_end_x,
    output logic signed [CW-1:0] o_end_y,
    output logic o_path_done
);

    logic [QW-1:0] r_smooth;
    logic [1:0] r_seen;
    logic signed [CW-1:0] r_bpx, r_bpy, r_px, r_py, r_nx, r_ny;
    logic r_second;                       // second curve of a final point pending

    // advance the pipeline whenever the output is free or empty
    logic adv, acc;
    logic p_valid;
    t_ctl p_ctl;
    logic signed [CW-1:0] c1x, c1y, c2x, c2y, ex, ey;
    assign adv = !(o_valid && i_stall);
    assign o_stall = !adv || r_second;
    assign acc = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    logic issue;
    t_quad q;
    t_ctl ctl;
    always_comb begin
        issue = 1'b0;
        q = '0;
        ctl = '{kind: KIND_MOVE, done: 1'b0};
        if (r_second) begin
            issue = adv;
            q = '{ax: DW'(r_bpx), ay: DW'(r_bpy), bx: r_px, by: r_py,
                  cx: r_nx, cy: r_ny,
                  dx: 2*DW'(r_nx) - DW'(r_px),
                  dy: 2*DW'(r_ny) - DW'(r_py)};
            ctl = '{kind: KIND_CURVE, done: 1'b1};
        end else if (acc) begin
            q.cx = i_point_x; q.cy = i_point_y;
            case (r_seen)
                2'd0: begin
                    issue = 1'b1;
                    ctl = '{kind: KIND_MOVE, done: i_last_point};
                end
                2'd1: begin
                    issue = i_last_point;
                    ctl = '{kind: KIND_LINE, done: 1'b1};
                end
                default: begin
                    issue = 1'b1;
                    q = '{ax: (r_seen == 2'd2) ? 2*DW'(r_px) - DW'(r_nx)
                                               : DW'(r_bpx),
                          ay: (r_seen == 2'd2) ? 2*DW'(r_py) - DW'(r_ny)
                                               : DW'(r_bpy),
                          bx: r_px, by: r_py, cx: r_nx, cy: r_ny,
                          dx: DW'(i_point_x), dy: DW'(i_point_y)};
                    ctl = '{kind: KIND_CURVE, done: 1'b0};
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smooth <= ONE_Q16;
            r_seen   <= '0;
            r_second <= 1'b0;
            r_bpx <= '0; r_bpy <= '0; r_px <= '0; r_py <= '0; r_nx <= '0; r_ny <= '0;
        end else begin
            if (i_cfg_valid) r_smooth <= i_cfg_smoothing;
            if (r_second && adv) begin
                r_second <= 1'b0;
                r_seen   <= '0;
            end else if (acc) begin
                case (r_seen)
                    2'd0: begin
                        if (!i_last_point) begin
                            r_nx <= i_point_x; r_ny <= i_point_y; r_seen <= 2'd1;
                        end
                    end
                    2'd1: begin
                        if (i_last_point) begin
                            r_seen <= '0;
                        end else begin
                            r_px <= r_nx; r_py <= r_ny;
                            r_nx <= i_point_x; r_ny <= i_point_y; r_seen <= 2'd2;
                        end
                    end
                    default: begin
                        r_bpx <= r_px; r_bpy <= r_py;
                        r_px <= r_nx; r_py <= r_ny;
                        r_nx <= i_point_x; r_ny <= i_point_y;
                        r_seen <= 2'd3;
                        r_second <= i_last_point;
                    end
                endcase
            end
        end
    end

    pbs_curve_pipe u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (issue),
        .i_quad  (q),
        .i_ctl   (ctl),
        .i_smooth(r_smooth),
        .o_valid (p_valid),
        .o_ctl   (p_ctl),
        .o_c1x   (c1x),
        .o_c1y   (c1y),
        .o_c2x   (c2x),
        .o_c2y   (c2y),
        .o_ex    (ex),
        .o_ey    (ey)
    );

    logic is_curve;
    assign is_curve = (p_ctl.kind == KIND_CURVE);
    assign o_valid        = p_valid;
    assign o_segment_kind = p_ctl.kind;
    assign o_path_done    = p_ctl.done;
    assign o_ctrl1_x = is_curve ? c1x : '0;
    assign o_ctrl1_y = is_curve ? c1y : '0;
    assign o_ctrl2_x = is_curve ? c2x : '0;
    assign o_ctrl2_y = is_curve ? c2y : '0;
    assign o_end_x = ex;
    assign o_end_y = ey;

endmodule

@@ hw/rtl/pbs_checker.sv @@
// Port-level checks for the polyline Bezier smoother, bound to the top level.
module pbs_checker
    import pbs_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_stall,
    input logic o_valid,
    input logic [1:0] o_segment_kind,
    input logic signed [CW-1:0] o_ctrl1_x,
    input logic signed [CW-1:0] o_ctrl2_y,
    input logic [CW-1:0] o_end_x
);

    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_segment_kind == KIND_MOVE || o_segment_kind == KIND_LINE ||
                     o_segment_kind == KIND_CURVE))
        else $error("bad segment kind");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_segment_kind != KIND_CURVE) |-> (o_ctrl1_x == '0 && o_ctrl2_y == '0))
        else $error("control point set on non-curve");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_end_x)))
        else $error("stalled item changed");

endmodule

bind polyline_bezier_smoother pbs_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_stall(i_stall), .o_valid(o_valid),
    .o_segment_kind(o_segment_kind), .o_ctrl1_x(o_ctrl1_x),
    .o_ctrl2_y(o_ctrl2_y), .o_end_x(o_end_x)
);

@@ test/tb_top.sv @@
// Self-checking testbench for the polyline Bezier smoother: random paths, idling, smoothing sweeps.
`timescale 1ns / 1ps
module tb_top;
    import pbs_pkg::*;

    typedef struct packed {
        logic signed [CW-1:0] px;
        logic signed [CW-1:0] py;
        logic                 last;
    } t_point;

    typedef struct packed {
        logic [1:0]           kind;
        logic signed [CW-1:0] c1x;
        logic signed [CW-1:0] c1y;
        logic signed [CW-1:0] c2x;
        logic signed [CW-1:0] c2y;
        logic signed [CW-1:0] ex;
        logic signed [CW-1:0] ey;
        logic                 done;
    } t_segment;

    localparam longint CMAX_L = 64'sd2147483647;
    localparam longint CMIN_L = -64'sd2147483648;
    localparam int     LIMIT_CYCLES = 2000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic signed [CW-1:0] i_point_x = '0;
    logic signed [CW-1:0] i_point_y = '0;
    logic i_last_point = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [QW-1:0] i_cfg_smoothing = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [1:0] o_segment_kind;
    logic signed [CW-1:0] o_ctrl1_x, o_ctrl1_y, o_ctrl2_x, o_ctrl2_y, o_end_x, o_end_y;
    logic o_path_done;

    polyline_bezier_smoother dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Predictor state
    int unsigned smooth_q16 = 65536;
    int          path_count = 0;
    longint      win_ax, win_ay, win_bx, win_by, win_cx, win_cy;

    t_point   pending_points[$];
    t_segment expected_segments[$];
    int       fail_count = 0;
    int       received_count = 0;
    longint   cycle_count = 0;
    bit       stim_done = 0;

    function automatic longint unsigned abs_u(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint unsigned edge_len(longint dx, longint dy);
        logic [127:0] sq;
        logic [127:0] root, rem, trial;
        sq = 128'(abs_u(dx)) * 128'(abs_u(dy)) * 0 + 128'(abs_u(dx)) * 128'(abs_u(dx))
             + 128'(abs_u(dy)) * 128'(abs_u(dy));
        root = 0;
        rem = 0;
        for (int i = 63; i >= 0; i--) begin
            rem = (rem << 2) | ((sq >> (2 * i)) & 128'd3);
            trial = (root << 2) | 128'd1;
            root = root << 1;
            if (rem >= trial) begin
                rem = rem - trial;
                root = root | 128'd1;
            end
        end
        return root[63:0];
    endfunction

    function automatic longint unsigned ratio16(longint unsigned la, longint unsigned lb);
        longint unsigned sum;
        sum = la + lb;
        if (sum == 0) return 0;
        return (la * 65536) / sum;
    endfunction

    function automatic longint half_scale(longint d, longint unsigned w);
        logic [127:0] prod;
        longint unsigned res;
        prod = 128'(abs_u(d)) * 128'(w) + 128'd65536;
        res = 64'(prod >> 17);
        return d < 0 ? -longint'(res) : longint'(res);
    endfunction

    function automatic logic signed [CW-1:0] clamp_coord(longint v);
        if (v > CMAX_L) return CMAX_L[CW-1:0];
        if (v < CMIN_L) return CMIN_L[CW-1:0];
        return v[CW-1:0];
    endfunction

    function automatic t_segment bezier_segment(longint ax, longint ay, longint bx, longint by,
                                                longint cx, longint cy, longint dx, longint dy,
                                                logic done);
        t_segment seg;
        longint unsigned s, k1, k2, w1, w2;
        s = smooth_q16 > 65536 ? 65536 : smooth_q16;
        k1 = ratio16(edge_len(bx - ax, by - ay), edge_len(cx - bx, cy - by));
        k2 = ratio16(edge_len(cx - bx, cy - by), edge_len(dx - cx, dy - cy));
        w1 = (s * (65536 - k1) + 32768) >> 16;
        w2 = (s * k2 + 32768) >> 16;
        seg.kind = KIND_CURVE;
        seg.c1x = clamp_coord(bx + half_scale(cx - ax, w1));
        seg.c1y = clamp_coord(by + half_scale(cy - ay, w1));
        seg.c2x = clamp_coord(cx - half_scale(dx - bx, w2));
        seg.c2y = clamp_coord(cy - half_scale(dy - by, w2));
        seg.ex = cx[CW-1:0];
        seg.ey = cy[CW-1:0];
        seg.done = done;
        return seg;
    endfunction

    task automatic predict_point(input t_point p);
        t_segment seg;
        longint px, py, ax, ay;
        px = p.px;
        py = p.py;
        seg = '0;
        if (path_count == 0) begin
            seg.kind = KIND_MOVE;
            seg.ex = p.px;
            seg.ey = p.py;
            seg.done = p.last;
            expected_segments.push_back(seg);
            if (!p.last) begin
                win_cx = px;
                win_cy = py;
                path_count = 1;
            end
        end else if (path_count == 1) begin
            if (p.last) begin
                seg.kind = KIND_LINE;
                seg.ex = p.px;
                seg.ey = p.py;
                seg.done = 1'b1;
                expected_segments.push_back(seg);
                path_count = 0;
            end else begin
                win_bx = win_cx;
                win_by = win_cy;
                win_cx = px;
                win_cy = py;
                path_count = 2;
            end
        end else begin
            // Phantom start point on the first curve of the path
            if (path_count == 2) begin
                ax = 2 * win_bx - win_cx;
                ay = 2 * win_by - win_cy;
            end else begin
                ax = win_ax;
                ay = win_ay;
            end
            expected_segments.push_back(bezier_segment(ax, ay, win_bx, win_by,
                                                       win_cx, win_cy, px, py, 1'b0));
            win_ax = win_bx;
            win_ay = win_by;
            win_bx = win_cx;
            win_by = win_cy;
            win_cx = px;
            win_cy = py;
            path_count = 3;
            if (p.last) begin
                expected_segments.push_back(bezier_segment(win_ax, win_ay, win_bx, win_by,
                                                           win_cx, win_cy, 2 * win_cx - win_bx,
                                                           2 * win_cy - win_by, 1'b1));
                path_count = 0;
            end
        end
    endtask

    function automatic int gap_len();
        if ($urandom_range(99) < 50) return 0;
        if ($urandom_range(99) < 90) return $urandom_range(3);
        return $urandom_range(40, 10);
    endfunction

    // Driver
    int send_gap = 0;
    bit idle_phase = 0;
    always @(posedge i_clk) begin
        t_point nxt;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                predict_point(pending_points.pop_front());
            end
            if (i_valid && o_stall) begin
                // hold the stalled item
            end else if (send_gap > 0) begin
                i_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (pending_points.size() > 0) begin
                nxt = pending_points[0];
                i_point_x <= nxt.px;
                i_point_y <= nxt.py;
                i_last_point <= nxt.last;
                i_valid <= 1'b1;
                send_gap <= idle_phase ? 0 : gap_len();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Monitor
    int stall_left = 0;
    always @(posedge i_clk) begin
        t_segment got, want;
        if (i_rst_n) begin
            cycle_count <= cycle_count + 1;
            if (o_valid && !i_stall) begin
                received_count <= received_count + 1;
                got = {o_segment_kind, o_ctrl1_x, o_ctrl1_y, o_ctrl2_x, o_ctrl2_y,
                       o_end_x, o_end_y, o_path_done};
                if (expected_segments.size() == 0) begin
                    $error("unexpected segment kind=%0d", got.kind);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_segments.pop_front();
                    if (got != want) begin
                        fail_count <= fail_count + 1;
                        if (got.kind != want.kind)
                            $error("segment_kind: expected %0d got %0d", want.kind, got.kind);
                        if (got.c1x != want.c1x)
                            $error("ctrl1_x: expected %0d got %0d", want.c1x, got.c1x);
                        if (got.c1y != want.c1y)
                            $error("ctrl1_y: expected %0d got %0d", want.c1y, got.c1y);
                        if (got.c2x != want.c2x)
                            $error("ctrl2_x: expected %0d got %0d", want.c2x, got.c2x);
                        if (got.c2y != want.c2y)
                            $error("ctrl2_y: expected %0d got %0d", want.c2y, got.c2y);
                        if (got.ex != want.ex)
                            $error("end_x: expected %0d got %0d", want.ex, got.ex);
                        if (got.ey != want.ey)
                            $error("end_y: expected %0d got %0d", want.ey, got.ey);
                        if (got.done != want.done)
                            $error("path_done: expected %0d got %0d", want.done, got.done);
                    end
                end
            end
            if (stall_left > 0) begin
                i_stall <= 1'b1;
                stall_left <= stall_left - 1;
            end else if (!idle_phase && $urandom_range(99) < 25) begin
                i_stall <= 1'b1;
                stall_left <= gap_len();
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic logic signed [CW-1:0] rand_coord();
        case ($urandom_range(5))
            0: return $urandom;
            1: return CW'(int'($urandom_range(4000)) - 2000);
            2: return $urandom_range(1) ? CMAX_L[CW-1:0] : CMIN_L[CW-1:0];
            default: return CW'(int'($urandom_range(2000000)) - 1000000);
        endcase
    endfunction

    task automatic add_point(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                             input logic last);
        t_point p;
        p.px = x;
        p.py = y;
        p.last = last;
        pending_points.push_back(p);
    endtask

    task automatic add_path(input int n);
        for (int i = 0; i < n; i++) add_point(rand_coord(), rand_coord(), i == n - 1);
    endtask

    task automatic drain_and_config(input logic [QW-1:0] value);
        wait (pending_points.size() == 0 && !i_valid && expected_segments.size() == 0);
        repeat (80) @(posedge i_clk);
        @(posedge i_clk);
        i_cfg_smoothing <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        smooth_q16 = value;
    endtask

    initial begin
        int budget;
        logic [QW-1:0] settings[5];
        settings = '{17'd65536, 17'd0, 17'd131071, 17'd32768, 17'd1};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: lone move, two-point line, extremes, zero-length edges
        add_point(CMAX_L[CW-1:0], CMIN_L[CW-1:0], 1'b1);
        add_point(32'sd0, 32'sd0, 1'b0);
        add_point(CMIN_L[CW-1:0], CMAX_L[CW-1:0], 1'b1);
        add_point(32'sd256, 32'sd256, 1'b0);
        add_point(32'sd256, 32'sd256, 1'b0);
        add_point(32'sd256, 32'sd256, 1'b1);
        add_point(CMIN_L[CW-1:0], CMIN_L[CW-1:0], 1'b0);
        add_point(CMAX_L[CW-1:0], CMAX_L[CW-1:0], 1'b0);
        add_point(CMIN_L[CW-1:0], CMAX_L[CW-1:0], 1'b0);
        add_point(CMAX_L[CW-1:0], CMIN_L[CW-1:0], 1'b1);
        add_point(32'sd100, -32'sd100, 1'b0);
        add_point(32'sd300, 32'sd500, 1'b0);
        add_point(-32'sd1, 32'sd0, 1'b1);
        add_point(32'sd0, 32'sd0, 1'b0);
        add_point(32'sd0, 32'sd0, 1'b0);
        add_point(32'sd1000, 32'sd0, 1'b0);
        add_point(32'sd1000, 32'sd0, 1'b1);

        for (int phase = 0; phase < 5; phase++) begin
            drain_and_config(settings[phase]);
            idle_phase = (phase == 2);
            budget = 310;
            while (budget > 0) begin
                int n;
                n = $urandom_range(99) < 10 ? $urandom_range(2, 1) : $urandom_range(12, 3);
                add_path(n);
                budget -= n;
            end
        end
        wait (pending_points.size() == 0 && !i_valid && expected_segments.size() == 0);
        repeat (80) @(posedge i_clk);
        if (fail_count == 0 && expected_segments.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule

@@ sim.f @@
hw/rtl/pbs_pkg.sv
hw/rtl/pbs_curve_pipe.sv
hw/rtl/polyline_bezier_smoother.sv
hw/rtl/pbs_checker.sv
test/tb_top.sv
